@@ src/running_median_two_heaps_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the running median block.
// ---------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// Assert that antecedent implies consequent in the same cycle.
`define RMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that antecedent implies consequent in the next cycle.
`define RMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rmh_pkg.sv @@
// ---------------------------------------------------------------------------
// rmh_pkg
// Shared types and constants of the running median block.
// ---------------------------------------------------------------------------
package rmh_pkg;
  localparam int unsigned Capacity  = 1024;
  localparam int unsigned HeapDepth = Capacity / 2 + 2;
  localparam int unsigned AddrW     = $clog2(HeapDepth);
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned SampleW   = 16;
  localparam int unsigned MedW      = 17;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [AddrW:0]   size_t;
  typedef logic signed [SampleW-1:0] sample_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_e;

  // Controller -> datapath
  typedef struct packed {
    logic    start;
    op_e     op;
    logic    heap_sel;   // 1: lower (max) heap, 0: upper (min) heap
    logic    load_x;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic    done;
    logic    x_above_top;
    size_t   lower_size;
    size_t   upper_size;
  } stat_t;
endpackage

@@ src/rmh_heap.sv @@
// ---------------------------------------------------------------------------
// rmh_heap
// One heap in block memory with a sift-up/sift-down sequencer; one memory
// access per cycle.
// ---------------------------------------------------------------------------
module rmh_heap (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             is_max_i,
  input  logic             push_i,
  input  logic             pop_i,
  input  rmh_pkg::sample_t val_i,
  output rmh_pkg::sample_t top_o,
  output rmh_pkg::sample_t pop_val_o,
  output rmh_pkg::size_t   size_o,
  output logic             busy_o
);
  import rmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_LD, S_DN_LAST, S_DN_C0, S_DN_C1, S_DN_CMP
  } st_e;

  sample_t mem [HeapDepth];
  st_e     st_q;
  size_t   size_q, cnt_q;
  addr_t   idx_q, c_q;
  sample_t v_q, top_q, rd_q, c0_q, popv_q;
  logic    mem_we;
  addr_t   mem_wa, mem_ra;
  sample_t mem_wd;
  logic    rd_en;

  function automatic logic above(sample_t a, sample_t b, logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  assign top_o     = top_q;
  assign pop_val_o = popv_q;
  assign size_o    = size_q;
  assign busy_o    = (st_q != S_IDLE);

  addr_t parent;
  logic [AddrW:0] c0w, c1w;
  assign parent = (idx_q - addr_t'(1)) >> 1;
  assign c0w    = {idx_q, 1'b1};
  assign c1w    = c0w + 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_q <= mem[mem_ra];
  end

  always_comb begin
    mem_we = 1'b0; mem_wa = idx_q; mem_wd = v_q; rd_en = 1'b0; mem_ra = idx_q;
    case (st_q)
      S_IDLE: begin
        if (pop_i) begin rd_en = 1'b1; mem_ra = addr_t'(size_q - 1'b1); end
      end
      S_UP_RD: begin
        if (idx_q == '0) mem_we = 1'b1;
        else begin rd_en = 1'b1; mem_ra = parent; end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (above(v_q, rd_q, is_max_i)) mem_wd = rd_q;
      end
      S_DN_LD: ;
      S_DN_LAST: begin
        if (c0w < cnt_q) begin rd_en = 1'b1; mem_ra = addr_t'(c0w); end
        else mem_we = 1'b1;
      end
      S_DN_C0: begin
        if (c1w < cnt_q) begin rd_en = 1'b1; mem_ra = addr_t'(c1w); end
      end
      S_DN_C1: ;
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (above(c0_q, v_q, is_max_i)) mem_wd = c0_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; size_q <= '0; cnt_q <= '0; idx_q <= '0; c_q <= '0;
      v_q <= '0; top_q <= '0; c0_q <= '0; popv_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (push_i) begin
            v_q <= val_i; idx_q <= addr_t'(size_q); size_q <= size_q + 1'b1;
            st_q <= S_UP_RD;
          end else if (pop_i) begin
            cnt_q <= size_q - 1'b1; size_q <= size_q - 1'b1; idx_q <= '0;
            popv_q <= top_q;
            st_q <= S_DN_LD;
          end
        end
        S_UP_RD: begin
          if (idx_q == '0) begin top_q <= v_q; st_q <= S_IDLE; end
          else st_q <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (above(v_q, rd_q, is_max_i)) begin
            if (parent == '0) top_q <= v_q;
            idx_q <= parent; st_q <= S_UP_RD;
          end else st_q <= S_IDLE;
        end
        S_DN_LD: begin
          v_q <= rd_q;
          st_q <= S_DN_LAST;
        end
        S_DN_LAST: begin
          if (c0w >= cnt_q) begin
            st_q <= S_IDLE;
            if (idx_q == '0 && cnt_q != '0) top_q <= v_q;
          end else begin
            st_q <= S_DN_C0;
          end
        end
        S_DN_C0: begin
          c0_q <= rd_q; c_q <= addr_t'(c0w);
          st_q <= (c1w < cnt_q) ? S_DN_C1 : S_DN_CMP;
        end
        S_DN_C1: begin
          if (above(rd_q, c0_q, is_max_i)) begin c0_q <= rd_q; c_q <= addr_t'(c1w); end
          st_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (above(c0_q, v_q, is_max_i)) begin
            if (idx_q == '0) top_q <= c0_q;
            idx_q <= c_q; st_q <= S_DN_LAST;
          end else begin
            if (idx_q == '0) top_q <= v_q;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/rmh_ctrl.sv @@
// ---------------------------------------------------------------------------
// rmh_ctrl
// Sequencer for insert and rebalance; owns the input and output handshakes.
// ---------------------------------------------------------------------------
module rmh_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  rmh_pkg::stat_t stat_i,
  output rmh_pkg::cmd_t  cmd_o,
  output logic capture_o,
  output logic drop_o
);
  import rmh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_INS, S_WAIT1, S_BAL, S_WAIT2, S_OUT} st_e;
  st_e st_q;
  logic drop_q, dout_q, ov_q;
  logic [CntW-1:0] tot;

  assign tot = CntW'(stat_i.lower_size) + CntW'(stat_i.upper_size);
  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign drop_o      = dout_q;
  assign capture_o   = (st_q == S_OUT) && (!ov_q || !out_stall_i);

  always_comb begin
    cmd_o = '{start: 1'b0, op: OP_NONE, heap_sel: 1'b1, load_x: 1'b0};
    case (st_q)
      S_IDLE: cmd_o.load_x = in_valid_i && !in_stall_o;
      S_INS: begin
        cmd_o.start = (tot < CntW'(Capacity));
        cmd_o.op = OP_PUSH;
        cmd_o.heap_sel = (stat_i.lower_size == '0) || !stat_i.x_above_top;
      end
      S_BAL: begin
        cmd_o.op = OP_POP;
        if (stat_i.upper_size > stat_i.lower_size) begin
          cmd_o.start = 1'b1; cmd_o.heap_sel = 1'b0;
        end else if (stat_i.lower_size > stat_i.upper_size + 1'b1) begin
          cmd_o.start = 1'b1; cmd_o.heap_sel = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; drop_q <= 1'b0; dout_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      ov_q <= capture_o || (ov_q && out_stall_i);
      if (capture_o) dout_q <= drop_q;
      case (st_q)
        S_IDLE: if (in_valid_i && !in_stall_o) st_q <= S_INS;
        S_INS: begin
          drop_q <= !cmd_o.start;
          st_q <= cmd_o.start ? S_WAIT1 : S_OUT;
        end
        S_WAIT1: if (stat_i.done) st_q <= S_BAL;
        S_BAL: st_q <= cmd_o.start ? S_WAIT2 : S_OUT;
        S_WAIT2: if (stat_i.done) st_q <= S_OUT;
        S_OUT: if (capture_o) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/rmh_dp.sv @@
// ---------------------------------------------------------------------------
// rmh_dp
// Datapath: two heaps, input sample, pop transfer and median result.
// ---------------------------------------------------------------------------
module rmh_dp (
  input  logic clk_i,
  input  logic rst_ni,
  input  rmh_pkg::sample_t sample_i,
  input  rmh_pkg::cmd_t    cmd_i,
  input  logic             capture_i,
  output rmh_pkg::stat_t   stat_o,
  output logic signed [rmh_pkg::MedW-1:0] med_o,
  output logic [rmh_pkg::CntW-1:0]        cnt_o
);
  import rmh_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_POP, T_PUSH} tr_e;
  tr_e tr_q;
  logic    sel_q;
  sample_t x_q;
  logic    lo_push, lo_pop, up_push, up_pop, lo_busy, up_busy;
  sample_t lo_top, up_top, lo_pv, up_pv, push_v;
  size_t   lo_sz, up_sz;
  logic    pop_start;

  assign pop_start = cmd_i.start && (cmd_i.op == OP_POP);
  assign push_v = (tr_q == T_PUSH) ? (sel_q ? up_pv : lo_pv) : x_q;
  assign lo_push = (cmd_i.start && cmd_i.op == OP_PUSH && cmd_i.heap_sel) ||
                   (tr_q == T_PUSH && sel_q);
  assign up_push = (cmd_i.start && cmd_i.op == OP_PUSH && !cmd_i.heap_sel) ||
                   (tr_q == T_PUSH && !sel_q);
  assign lo_pop  = pop_start && cmd_i.heap_sel;
  assign up_pop  = pop_start && !cmd_i.heap_sel;

  rmh_heap u_lo (.clk_i, .rst_ni, .is_max_i(1'b1), .push_i(lo_push), .pop_i(lo_pop),
    .val_i(push_v), .top_o(lo_top), .pop_val_o(lo_pv), .size_o(lo_sz), .busy_o(lo_busy));
  rmh_heap u_up (.clk_i, .rst_ni, .is_max_i(1'b0), .push_i(up_push), .pop_i(up_pop),
    .val_i(push_v), .top_o(up_top), .pop_val_o(up_pv), .size_o(up_sz), .busy_o(up_busy));

  logic busy;
  assign busy = lo_busy || up_busy || lo_push || up_push || lo_pop || up_pop ||
                (tr_q != T_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q <= T_IDLE; sel_q <= 1'b0;
    end else begin
      case (tr_q)
        T_IDLE: if (pop_start) begin tr_q <= T_POP; sel_q <= !cmd_i.heap_sel; end
        T_POP:  if (!lo_busy && !up_busy) tr_q <= T_PUSH;
        T_PUSH: tr_q <= T_IDLE;
        default: tr_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) x_q <= sample_i;
  end

  assign stat_o.done        = !busy;
  assign stat_o.x_above_top = x_q > lo_top;
  assign stat_o.lower_size  = lo_sz;
  assign stat_o.upper_size  = up_sz;

  logic signed [MedW-1:0] med_d;
  always_comb begin
    if (lo_sz == '0) med_d = '0;
    else if (lo_sz > up_sz || up_sz == '0) med_d = {lo_top, 1'b0};
    else med_d = MedW'(lo_top) + MedW'(up_top);
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      med_o <= med_d;
      cnt_o <= CntW'(lo_sz) + CntW'(up_sz);
    end
  end
endmodule

@@ src/running_median_two_heaps.sv @@
// ---------------------------------------------------------------------------
// running_median_two_heaps
// Running median of a signed 16-bit stream kept in a max-heap and a min-heap.
// ---------------------------------------------------------------------------
// Input channel: sample_i with in_valid_i / in_stall_o. Output channel:
// median_doubled_o, stored_count_o, dropped_o with out_valid_o / out_stall_i.
// One word in gives one word out. Each heap sits in its own single-port
// memory and is walked one level at a time: a push reads and compares one
// parent per level, a pop reads the children and compares the winner. An
// item runs an insert and at most one pop-and-push between the heaps; a
// dropped sample skips both. Items are processed one at a time.
// Reset empties both heaps at once; memory contents need no clearing.
// A stalled result holds in the output register; a new word may be taken
// while it waits, and its result waits until the old one leaves.
// When 1024 samples are held, a new sample is dropped and flagged.
// ---------------------------------------------------------------------------
module running_median_two_heaps (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [16:0] median_doubled_o,
  output logic [10:0] stored_count_o,
  output logic dropped_o
);
  import rmh_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  drop, capture;
  logic  ov;

  rmh_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o(ov),
    .out_stall_i, .stat_i(stat), .cmd_o(cmd), .capture_o(capture), .drop_o(drop));

  rmh_dp u_dp (.clk_i, .rst_ni, .sample_i, .cmd_i(cmd), .capture_i(capture),
    .stat_o(stat), .med_o(median_doubled_o), .cnt_o(stored_count_o));

  assign out_valid_o = ov;
  assign dropped_o   = drop;
endmodule

@@ src/running_median_two_heaps_checker.sv @@
// ---------------------------------------------------------------------------
// running_median_two_heaps_checker
// Port-level checks of the running median block.
// ---------------------------------------------------------------------------
`include "running_median_two_heaps_macros.svh"
module running_median_two_heaps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [10:0] stored_count_o,
  input logic dropped_o,
  input logic signed [16:0] median_doubled_o
);
  `RMH_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(stored_count_o) && $stable(median_doubled_o) && $stable(dropped_o),
    "result changed while stalled")
  `RMH_ASSERT_IMP(a_cnt, clk_i, rst_ni, out_valid_o,
    stored_count_o <= 11'd1024, "count above capacity")
  `RMH_ASSERT_IMP(a_drop, clk_i, rst_ni, out_valid_o && dropped_o,
    stored_count_o == 11'd1024, "drop below capacity")
  `RMH_ASSERT_NEXT(a_seq, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o, "input taken while busy")
endmodule

bind running_median_two_heaps running_median_two_heaps_checker u_chk (.*);
